// File: hw/rtl/tnorm_pkg.sv
// Shared types and fixed constants for the triangle unit-normal pipeline.
// No dependencies; imported by every tnorm module.
`default_nettype none
package tnorm_pkg;

  // Output component width, fixed by the result format.
  localparam int OUT_W = 32;

  // Control that travels with each beat once the cross product is known.
  typedef struct packed {
    logic       vld;
    logic [2:0] neg;
    logic       degen;
  } tnorm_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/tnorm_cross.sv
// Edge vectors, cross product and component magnitudes (four stages).
// Depends on tnorm_pkg.
`default_nettype none
module tnorm_cross #(
  parameter int CB = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic signed [CB-1:0]   va [3],
  input  logic signed [CB-1:0]   vb [3],
  input  logic signed [CB-1:0]   vc [3],
  output logic [2*CB+1:0]        mag_o [3],
  output tnorm_pkg::tnorm_ctl_t  ctl_o
);
  import tnorm_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;

  logic                 v1_r, v2_r, v3_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] d1_nxt [3];
  logic signed [DW-1:0] d2_nxt [3];
  logic signed [PW-1:0] p_r [6];
  logic signed [PW-1:0] p_nxt [6];
  logic signed [PW-1:0] n_r [3];
  logic signed [PW-1:0] n_nxt [3];
  logic [PW-1:0]        mag_r [3];
  logic [PW-1:0]        mag_nxt [3];
  tnorm_ctl_t           ctl_r;
  tnorm_ctl_t           ctl_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1_nxt[k] = DW'(vb[k]) - DW'(va[k]);
      d2_nxt[k] = DW'(vc[k]) - DW'(va[k]);
    end
  end

  always_comb begin
    p_nxt[0] = PW'(d1_r[1]) * PW'(d2_r[2]);
    p_nxt[1] = PW'(d1_r[2]) * PW'(d2_r[1]);
    p_nxt[2] = PW'(d1_r[2]) * PW'(d2_r[0]);
    p_nxt[3] = PW'(d1_r[0]) * PW'(d2_r[2]);
    p_nxt[4] = PW'(d1_r[0]) * PW'(d2_r[1]);
    p_nxt[5] = PW'(d1_r[1]) * PW'(d2_r[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = p_r[2*k] - p_r[2*k+1];
    end
  end

  // Take magnitudes; a zero cross product marks the triangle degenerate.
  always_comb begin
    ctl_nxt.vld   = v3_r;
    ctl_nxt.degen = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    for (int k = 0; k < 3; k++) begin
      ctl_nxt.neg[k] = n_r[k][PW-1];
      mag_nxt[k]     = n_r[k][PW-1] ? PW'(-n_r[k]) : PW'(n_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      v1_r  <= in_vld;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
      p_r   <= p_nxt;
      n_r   <= n_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign mag_o = mag_r;
  assign ctl_o = ctl_r;

endmodule
`default_nettype wire

// File: hw/rtl/tnorm_square.sv
// Squared length of the cross product from split partial products (three stages).
// Depends on tnorm_pkg.
`default_nettype none
module tnorm_square #(
  parameter int MW = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [MW-1:0]         mag_i [3],
  input  tnorm_pkg::tnorm_ctl_t ctl_i,
  output logic [MW-1:0]         mag_o [3],
  output logic [2*MW-1:0]       l2_o,
  output tnorm_pkg::tnorm_ctl_t ctl_o
);
  import tnorm_pkg::*;

  localparam int HW = MW / 2;
  localparam int LW = 2 * MW;

  logic [MW-1:0] hh_r [3];
  logic [MW-1:0] hl_r [3];
  logic [MW-1:0] ll_r [3];
  logic [MW-1:0] hh_nxt [3];
  logic [MW-1:0] hl_nxt [3];
  logic [MW-1:0] ll_nxt [3];
  logic [LW-1:0] sq_r [3];
  logic [LW-1:0] sq_nxt [3];
  logic [LW-1:0] l2_r;
  logic [LW-1:0] l2_nxt;
  logic [MW-1:0] m5_r [3];
  logic [MW-1:0] m6_r [3];
  logic [MW-1:0] m7_r [3];
  tnorm_ctl_t    c5_r, c6_r, c7_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = MW'(mag_i[k][MW-1:HW]) * MW'(mag_i[k][MW-1:HW]);
      hl_nxt[k] = MW'(mag_i[k][MW-1:HW]) * MW'(mag_i[k][HW-1:0]);
      ll_nxt[k] = MW'(mag_i[k][HW-1:0]) * MW'(mag_i[k][HW-1:0]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = (LW'(hh_r[k]) << MW) + (LW'(hl_r[k]) << (HW + 1)) + LW'(ll_r[k]);
    end
    l2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
    end else if (adv) begin
      c5_r <= ctl_i;
      c6_r <= c5_r;
      c7_r <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      ll_r <= ll_nxt;
      sq_r <= sq_nxt;
      l2_r <= l2_nxt;
      m5_r <= mag_i;
      m6_r <= m5_r;
      m7_r <= m6_r;
    end
  end

  assign mag_o = m7_r;
  assign l2_o  = l2_r;
  assign ctl_o = c7_r;

endmodule
`default_nettype wire

// File: hw/rtl/tnorm_sqrt.sv
// Floored square root, one root bit per pipeline stage, MW stages.
// Depends on tnorm_pkg.
`default_nettype none
module tnorm_sqrt #(
  parameter int MW = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [2*MW-1:0]       l2_i,
  input  logic [MW-1:0]         mag_i [3],
  input  tnorm_pkg::tnorm_ctl_t ctl_i,
  output logic [MW-1:0]         root_o,
  output logic [MW-1:0]         mag_o [3],
  output tnorm_pkg::tnorm_ctl_t ctl_o
);
  import tnorm_pkg::*;

  localparam int LW = 2 * MW;

  logic [LW-1:0] rem_c  [MW+1];
  logic [MW-1:0] root_c [MW+1];
  logic [MW-1:0] mag_c  [MW+1][3];
  tnorm_ctl_t    ctl_c  [MW+1];

  assign rem_c[0]  = l2_i;
  assign root_c[0] = '0;
  assign mag_c[0]  = mag_i;
  assign ctl_c[0]  = ctl_i;

  for (genvar g = 0; g < MW; g++) begin : g_stage
    localparam int BI = MW - 1 - g;
    logic [LW-1:0] trial;
    logic [LW-1:0] rem_r, rem_nxt;
    logic [MW-1:0] root_r, root_nxt;
    logic [MW-1:0] mag_r [3];
    tnorm_ctl_t    ctl_r;

    // Try root bit BI: subtract (root << (BI+1)) + 4^BI if it fits.
    always_comb begin
      trial = (LW'(root_c[g]) << (BI + 1)) | (LW'(1) << (2 * BI));
      if (trial <= rem_c[g]) begin
        rem_nxt  = rem_c[g] - trial;
        root_nxt = root_c[g] | (MW'(1) << BI);
      end else begin
        rem_nxt  = rem_c[g];
        root_nxt = root_c[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else if (adv) begin
        ctl_r <= ctl_c[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        mag_r  <= mag_c[g];
      end
    end

    assign rem_c[g+1]  = rem_r;
    assign root_c[g+1] = root_r;
    assign mag_c[g+1]  = mag_r;
    assign ctl_c[g+1]  = ctl_r;
  end

  assign root_o = root_c[MW];
  assign mag_o  = mag_c[MW];
  assign ctl_o  = ctl_c[MW];

endmodule
`default_nettype wire

// File: hw/rtl/tnorm_div.sv
// Three parallel restoring dividers, one quotient bit per stage, NF+1 stages.
// Depends on tnorm_pkg.
`default_nettype none
module tnorm_div #(
  parameter int MW = 50,
  parameter int NF = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [MW-1:0]         root_i,
  input  logic [MW-1:0]         mag_i [3],
  input  tnorm_pkg::tnorm_ctl_t ctl_i,
  output logic [NF-1:0]         q_o [3],
  output logic [2:0]            sat_o,
  output tnorm_pkg::tnorm_ctl_t ctl_o
);
  import tnorm_pkg::*;

  logic [MW-1:0] s_c   [NF+1];
  logic [MW-1:0] rem_c [NF+1][3];
  logic [NF-1:0] q_c   [NF+1][3];
  logic [2:0]    sat_c [NF+1];
  tnorm_ctl_t    ctl_c [NF+1];

  // Entry stage: a component at or above the root saturates to one.
  logic [MW-1:0] s0_r;
  logic [MW-1:0] rem0_r [3];
  logic [2:0]    sat0_r, sat0_nxt;
  tnorm_ctl_t    ctl0_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat0_nxt[k] = (mag_i[k] >= root_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv) begin
      ctl0_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r   <= root_i;
      rem0_r <= mag_i;
      sat0_r <= sat0_nxt;
    end
  end

  assign s_c[0]   = s0_r;
  assign rem_c[0] = rem0_r;
  assign sat_c[0] = sat0_r;
  assign ctl_c[0] = ctl0_r;
  assign q_c[0]   = '{default: '0};

  for (genvar g = 0; g < NF; g++) begin : g_stage
    logic [MW:0]   shifted [3];
    logic [MW-1:0] rem_nxt [3];
    logic [NF-1:0] q_nxt   [3];
    logic [MW-1:0] s_r;
    logic [MW-1:0] rem_r [3];
    logic [NF-1:0] q_r   [3];
    logic [2:0]    sat_r;
    tnorm_ctl_t    ctl_r;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        shifted[k] = {rem_c[g][k], 1'b0};
        if (shifted[k] >= {1'b0, s_c[g]}) begin
          rem_nxt[k] = MW'(shifted[k] - {1'b0, s_c[g]});
          q_nxt[k]   = {q_c[g][k][NF-2:0], 1'b1};
        end else begin
          rem_nxt[k] = shifted[k][MW-1:0];
          q_nxt[k]   = {q_c[g][k][NF-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else if (adv) begin
        ctl_r <= ctl_c[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_r   <= s_c[g];
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        sat_r <= sat_c[g];
      end
    end

    assign s_c[g+1]   = s_r;
    assign rem_c[g+1] = rem_r;
    assign q_c[g+1]   = q_r;
    assign sat_c[g+1] = sat_r;
    assign ctl_c[g+1] = ctl_r;
  end

  assign q_o   = q_c[NF];
  assign sat_o = sat_c[NF];
  assign ctl_o = ctl_c[NF];

endmodule
`default_nettype wire

// File: hw/rtl/triangle_unit_normal_core.sv
// Top level of the triangle unit-normal pipeline: vertex beats in, Q1.NF normal beats out.
// Depends on tnorm_pkg, tnorm_cross, tnorm_square, tnorm_sqrt and tnorm_div.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------------------------
//   in_      | input     | in_valid / in_stall   | nine vertex coordinates, COORD_BITS each
//   out_     | output    | out_valid / out_stall | normal_x/y/z (32b signed), degenerate
//
// Throughput is one beat per cycle unless out_stall holds the output beat. Most of the
// pipeline depth lies in the square-root chain (one root bit per stage) and the
// divider chain (one quotient bit per stage).
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
// The whole pipeline advances together: when the output beat is held by out_stall, every
// stage holds and in_stall rises, so nothing is dropped or repeated.
`default_nettype none
module triangle_unit_normal_core #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0]       in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0]       in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0]       in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0]       in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0]       in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0]       in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0]       in_vertex_c_y,
  input  logic signed [COORD_BITS-1:0]       in_vertex_c_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tnorm_pkg::OUT_W-1:0] out_normal_x,
  output logic signed [tnorm_pkg::OUT_W-1:0] out_normal_y,
  output logic signed [tnorm_pkg::OUT_W-1:0] out_normal_z,
  output logic                               out_degenerate
);
  import tnorm_pkg::*;

  // Cross-product magnitude width; the squared length is twice this.
  localparam int MW = 2 * COORD_BITS + 2;
  localparam int NF = NORMAL_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) <<< NF;

  logic adv;

  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];

  logic [MW-1:0]   x_mag [3];
  tnorm_ctl_t      x_ctl;
  logic [MW-1:0]   q_mag [3];
  logic [2*MW-1:0] q_l2;
  tnorm_ctl_t      q_ctl;
  logic [MW-1:0]   r_root;
  logic [MW-1:0]   r_mag [3];
  tnorm_ctl_t      r_ctl;
  logic [NF-1:0]   d_q [3];
  logic [2:0]      d_sat;
  tnorm_ctl_t      d_ctl;

  logic                    out_vld_r;
  logic signed [OUT_W-1:0] nrm_r [3];
  logic signed [OUT_W-1:0] nrm_nxt [3];
  logic                    degen_r;
  logic [NF:0]             qmag [3];

  // Advance every stage unless a finished beat is waiting on a stalled sink.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  assign va = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
  assign vb = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
  assign vc = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};

  tnorm_cross #(.CB(COORD_BITS)) u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .va     (va),
    .vb     (vb),
    .vc     (vc),
    .mag_o  (x_mag),
    .ctl_o  (x_ctl)
  );

  tnorm_square #(.MW(MW)) u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .mag_i (x_mag),
    .ctl_i (x_ctl),
    .mag_o (q_mag),
    .l2_o  (q_l2),
    .ctl_o (q_ctl)
  );

  tnorm_sqrt #(.MW(MW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .l2_i   (q_l2),
    .mag_i  (q_mag),
    .ctl_i  (q_ctl),
    .root_o (r_root),
    .mag_o  (r_mag),
    .ctl_o  (r_ctl)
  );

  tnorm_div #(.MW(MW), .NF(NF)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .root_i (r_root),
    .mag_i  (r_mag),
    .ctl_i  (r_ctl),
    .q_o    (d_q),
    .sat_o  (d_sat),
    .ctl_o  (d_ctl)
  );

  // Format the output beat: saturate to one, restore the sign, zero a degenerate face.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qmag[k] = d_sat[k] ? ((NF+1)'(1) << NF) : {1'b0, d_q[k]};
      if (d_ctl.degen) begin
        nrm_nxt[k] = '0;
      end else if (d_ctl.neg[k]) begin
        nrm_nxt[k] = -OUT_W'(qmag[k]);
      end else begin
        nrm_nxt[k] = OUT_W'(qmag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_ctl.vld;
    end
  end

  // Hold the payload while the beat is stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_r   <= nrm_nxt;
      degen_r <= d_ctl.degen;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = degen_r;

  // A degenerate face must come out as the zero vector.
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate beat with nonzero normal");

  // Every component stays within plus or minus one.
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_normal_x <= ONE_Q && out_normal_x >= -ONE_Q &&
      out_normal_y <= ONE_Q && out_normal_y >= -ONE_Q &&
      out_normal_z <= ONE_Q && out_normal_z >= -ONE_Q)
    else $error("normal component out of range");

  // The input side stalls exactly when a finished beat is held at the output.
  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output hold");

endmodule
`default_nettype wire
